FILE: sv/asbs_pkg.sv
// Shared types and constants of the aim-settle burst sequencer.
`default_nettype none

package asbs_pkg;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_MOVE   = 3'd1,
		PH_SETTLE = 3'd2,
		PH_OPEN   = 3'd3,
		PH_COOL   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		REQ_SHOT  = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_ABORT = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		RJ_NONE     = 2'd0,
		RJ_BUSY     = 2'd1,
		RJ_COOL     = 2'd2,
		RJ_DURATION = 2'd3
	} reject_t;

	typedef enum logic [2:0] {
		CFG_MAX_BURST    = 3'd0,
		CFG_MOVE_TIMEOUT = 3'd1,
		CFG_SETTLE_TOL   = 3'd2,
		CFG_SETTLE_MS    = 3'd3,
		CFG_COOLDOWN     = 3'd4
	} cfg_idx_t;

	localparam logic [15:0] MAX_BURST_RST    = 16'd1000;
	localparam logic [15:0] MOVE_TIMEOUT_RST = 16'd5000;
	localparam logic [14:0] SETTLE_TOL_RST   = 15'd64;
	localparam logic [15:0] SETTLE_MS_RST    = 16'd200;
	localparam logic [15:0] COOLDOWN_RST     = 16'd2000;

endpackage

`default_nettype wire

FILE: sv/asbs_if.sv
// Valid/ready word channels for the sequencer's input items and results.
`default_nettype none

interface asbs_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [31:0]        now_ms;
	logic signed [15:0] target_pan;
	logic signed [15:0] target_tilt;
	logic [15:0]        burst_ms;
	logic signed [15:0] measured_pan;
	logic signed [15:0] measured_tilt;

	modport source (
		output valid, req_type, now_ms, target_pan, target_tilt, burst_ms,
		       measured_pan, measured_tilt,
		input  ready
	);
	modport sink (
		input  valid, req_type, now_ms, target_pan, target_tilt, burst_ms,
		       measured_pan, measured_tilt,
		output ready
	);
endinterface

interface asbs_out_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [1:0]  reject_reason;
	logic        valve_open;
	logic [2:0]  phase;
	logic [31:0] shot_count;

	modport source (
		output valid, accepted, reject_reason, valve_open, phase, shot_count,
		input  ready
	);
	modport sink (
		input  valid, accepted, reject_reason, valve_open, phase, shot_count,
		output ready
	);
endinterface

`default_nettype wire

FILE: sv/aim_settle_burst_sequencer_unit.sv
// Top level of the aim-settle burst sequencer: input stage, phase logic, result register.
`default_nettype none

// The block sequences one aimed valve burst through idle, move, settle, open
// and cooldown. Each word on the item channel is a shot request, a time tick
// or an abort stamped with a wrapping millisecond time; each one produces
// exactly one word on the result channel, in order.
// An item is captured in an input stage register, the next phase and the
// result are formed by one pass of compare logic (a 32-bit elapsed-time
// subtract and compare, two angle error compares), and both the state and
// the result register load at the same edge. An item passes through the
// input stage register and then the result register, and one item is taken
// every cycle as long as the receiver keeps up.
// When the receiver stalls, the result register holds its word and the input
// stage holds one more item; item ready drops only when both are full, so
// nothing is lost or repeated.
// Reset clears the phase to idle, the valve to closed, the shot counter and
// the time stamp to zero, and loads the configuration registers with their
// defaults. Configuration is written over the APB port, register i at byte
// address 4*i; pready is always high and reads return the register value.
module aim_settle_burst_sequencer_unit (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [asbs_pkg::PADDR_W-1:0]  paddr,
	input  wire [asbs_pkg::PDATA_W-1:0]  pwdata,
	output logic [asbs_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	asbs_in_if.sink                      item,
	asbs_out_if.source                   result
);
	import asbs_pkg::*;

	// Configuration registers.
	logic [15:0] max_burst_q;
	logic [15:0] move_timeout_q;
	logic [14:0] settle_tol_q;
	logic [15:0] settle_ms_q;
	logic [15:0] cooldown_q;

	// Input stage.
	logic               v_s1;
	req_kind_t          kind_s1;
	logic [31:0]        now_s1;
	logic signed [15:0] tpan_s1;
	logic signed [15:0] ttilt_s1;
	logic [15:0]        burst_s1;
	logic signed [15:0] mpan_s1;
	logic signed [15:0] mtilt_s1;

	// Sequencer state.
	phase_t             phase_q;
	logic [31:0]        stamp_q;
	logic signed [15:0] lpan_q;
	logic signed [15:0] ltilt_q;
	logic [15:0]        lburst_q;
	logic               valve_q;
	logic [31:0]        shot_q;

	// Next state and result.
	phase_t             phase_d;
	logic [31:0]        stamp_d;
	logic signed [15:0] lpan_d;
	logic signed [15:0] ltilt_d;
	logic [15:0]        lburst_d;
	logic               valve_d;
	logic [31:0]        shot_d;
	logic               acc_d;
	reject_t            why_d;

	// Result register.
	logic               out_v_q;
	logic               acc_q;
	reject_t            why_q;
	logic               valve_out_q;
	phase_t             phase_out_q;
	logic [31:0]        shot_out_q;

	logic               adv;
	logic               cfg_wr;
	cfg_idx_t           cfg_idx;
	logic [31:0]        elapsed;
	logic signed [16:0] dpan;
	logic signed [16:0] dtilt;
	logic [16:0]        apan;
	logic [16:0]        atilt;
	logic               arrived;

	// ---------------------------------------------------------------- APB port
	assign pready  = 1'b1;
	assign cfg_idx = cfg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_burst_q    <= MAX_BURST_RST;
			move_timeout_q <= MOVE_TIMEOUT_RST;
			settle_tol_q   <= SETTLE_TOL_RST;
			settle_ms_q    <= SETTLE_MS_RST;
			cooldown_q     <= COOLDOWN_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				CFG_MAX_BURST:    max_burst_q    <= pwdata[15:0];
				CFG_MOVE_TIMEOUT: move_timeout_q <= pwdata[15:0];
				CFG_SETTLE_TOL:   settle_tol_q   <= pwdata[14:0];
				CFG_SETTLE_MS:    settle_ms_q    <= pwdata[15:0];
				CFG_COOLDOWN:     cooldown_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			CFG_MAX_BURST:    prdata = {16'd0, max_burst_q};
			CFG_MOVE_TIMEOUT: prdata = {16'd0, move_timeout_q};
			CFG_SETTLE_TOL:   prdata = {17'd0, settle_tol_q};
			CFG_SETTLE_MS:    prdata = {16'd0, settle_ms_q};
			CFG_COOLDOWN:     prdata = {16'd0, cooldown_q};
			default:          prdata = '0;
		endcase
	end

	// ------------------------------------------------------------ handshakes
	// The input stage moves on whenever the result register is empty or is
	// being emptied in the same cycle.
	assign adv        = v_s1 && (!out_v_q || result.ready);
	assign item.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			kind_s1  <= req_kind_t'(item.req_type);
			now_s1   <= item.now_ms;
			tpan_s1  <= item.target_pan;
			ttilt_s1 <= item.target_tilt;
			burst_s1 <= item.burst_ms;
			mpan_s1  <= item.measured_pan;
			mtilt_s1 <= item.measured_tilt;
		end
	end

	// ------------------------------------------------------------ phase logic
	// Elapsed time wraps modulo two to the 32, so a plain subtract is exact.
	assign elapsed = now_s1 - stamp_q;

	// Angle errors need one extra bit; their magnitudes fit in 17 bits unsigned.
	assign dpan    = 17'(signed'({mpan_s1[15], mpan_s1})) - 17'(signed'({lpan_q[15], lpan_q}));
	assign dtilt   = 17'(signed'({mtilt_s1[15], mtilt_s1})) - 17'(signed'({ltilt_q[15], ltilt_q}));
	assign apan    = dpan[16] ? 17'(-dpan) : 17'(dpan);
	assign atilt   = dtilt[16] ? 17'(-dtilt) : 17'(dtilt);
	assign arrived = (apan <= {2'd0, settle_tol_q}) && (atilt <= {2'd0, settle_tol_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			stamp_q  <= '0;
			lpan_q   <= '0;
			ltilt_q  <= '0;
			lburst_q <= '0;
			valve_q  <= 1'b0;
			shot_q   <= '0;
		end else if (adv) begin
			phase_q  <= phase_d;
			stamp_q  <= stamp_d;
			lpan_q   <= lpan_d;
			ltilt_q  <= ltilt_d;
			lburst_q <= lburst_d;
			valve_q  <= valve_d;
			shot_q   <= shot_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		stamp_d  = stamp_q;
		lpan_d   = lpan_q;
		ltilt_d  = ltilt_q;
		lburst_d = lburst_q;
		valve_d  = valve_q;
		shot_d   = shot_q;
		acc_d    = 1'b0;
		why_d    = RJ_NONE;
		case (kind_s1)
			REQ_SHOT: begin
				if (phase_q != PH_IDLE) begin
					why_d = (phase_q == PH_COOL) ? RJ_COOL : RJ_BUSY;
				end else if (burst_s1 == 16'd0) begin
					why_d = RJ_DURATION;
				end else begin
					lpan_d   = tpan_s1;
					ltilt_d  = ttilt_s1;
					lburst_d = (burst_s1 > max_burst_q) ? max_burst_q : burst_s1;
					phase_d  = PH_MOVE;
					stamp_d  = now_s1;
					acc_d    = 1'b1;
				end
			end
			REQ_TICK: begin
				case (phase_q)
					PH_MOVE: begin
						// A timeout wins over arrival on the same tick.
						if (elapsed >= {16'd0, move_timeout_q}) begin
							phase_d = PH_IDLE;
						end else if (arrived) begin
							phase_d = PH_SETTLE;
							stamp_d = now_s1;
						end
					end
					PH_SETTLE: begin
						if (elapsed >= {16'd0, settle_ms_q}) begin
							phase_d = PH_OPEN;
							stamp_d = now_s1;
							valve_d = 1'b1;
						end
					end
					PH_OPEN: begin
						if (elapsed >= {16'd0, lburst_q}) begin
							valve_d = 1'b0;
							shot_d  = shot_q + 32'd1;
							phase_d = PH_COOL;
							stamp_d = now_s1;
						end
					end
					PH_COOL: begin
						if (elapsed >= {16'd0, cooldown_q}) begin
							phase_d = PH_IDLE;
						end
					end
					default: ;
				endcase
			end
			REQ_ABORT: begin
				case (phase_q)
					PH_MOVE, PH_SETTLE: begin
						valve_d = 1'b0;
						phase_d = PH_IDLE;
					end
					PH_OPEN: begin
						// A burst cut short still counts as a shot.
						valve_d = 1'b0;
						shot_d  = shot_q + 32'd1;
						phase_d = PH_COOL;
						stamp_d = now_s1;
					end
					PH_COOL: valve_d = 1'b0;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_q       <= acc_d;
			why_q       <= why_d;
			valve_out_q <= valve_d;
			phase_out_q <= phase_d;
			shot_out_q  <= shot_d;
		end
	end

	assign result.valid         = out_v_q;
	assign result.accepted      = acc_q;
	assign result.reject_reason = why_q;
	assign result.valve_open    = valve_out_q;
	assign result.phase         = phase_out_q;
	assign result.shot_count    = shot_out_q;

`ifndef ASSERT_OFF
	// The valve is driven exactly while a burst is open.
	a_valve_phase: assert property (@(posedge clk) disable iff (!arst_n)
		valve_q == (phase_q == PH_OPEN))
		else $error("valve level disagrees with phase");

	// The shot counter only steps by one, on leaving the open phase.
	a_shot_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(shot_q) |-> (shot_q == $past(shot_q) + 32'd1) &&
			($past(phase_q) == PH_OPEN) && (phase_q == PH_COOL))
		else $error("shot counter changed outside a burst end");

	// A held input stage item is not dropped while the result side stalls.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1)
		else $error("stalled input stage item lost");

	// An accepted request always reports the move phase.
	a_acc_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && acc_q |-> (phase_out_q == PH_MOVE) && (why_q == RJ_NONE))
		else $error("accepted request without move phase");
`endif

endmodule

`default_nettype wire
